### hw/rtl/mmcc_pkg.sv
package mmcc_pkg;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;

    localparam int STATUS1_READY_BIT = 0;
    localparam int STATUS2_OVF_BIT   = 3;

    localparam int RAW_W   = 16;
    localparam int XR_W    = 17;
    localparam int HY_W    = 18;
    localparam int MAG_W   = 16;
    localparam int CNT_W   = 10;
    localparam int SCALE_W = 32;
    localparam int OUT_W   = 32;
    localparam int OFF_W   = 48;
    localparam int SUM_W   = OFF_W + 1;
    localparam int PROD_W  = SCALE_W + HY_W;

    localparam logic [CNT_W-1:0]        CAL_SAMPLES_RST = 10'd500;
    localparam logic signed [RAW_W-1:0] BOUND_HI        = 16'sh7FFF;
    localparam logic signed [RAW_W-1:0] BOUND_LO        = 16'sh8001;
    localparam logic signed [OUT_W-1:0] INT32_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] INT32_MIN       = 32'sh8000_0000;

    typedef struct packed {
        logic capture;
        logic clear_held;
        logic start_cal;
        logic mul_sample;
        logic add;
        logic correct;
        logic fin_start;
        logic scale_load;
        logic mul_fin;
        logic yoff_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       data_ready;
        logic       overflow;
        logic       cal_active;
        logic       count_hit;
        logic       div_busy;
    } status_t;

endpackage

### hw/rtl/mmcc_if.sv
interface mmcc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] status_one;
    logic [7:0] x_low;
    logic [7:0] x_high;
    logic [7:0] y_low;
    logic [7:0] y_high;
    logic [7:0] z_low;
    logic [7:0] z_high;
    logic [7:0] status_two;

    modport source (
        output valid, op, status_one, x_low, x_high, y_low, y_high, z_low, z_high,
               status_two,
        input  ready
    );
    modport sink (
        input  valid, op, status_one, x_low, x_high, y_low, y_high, z_low, z_high,
               status_two,
        output ready
    );
endinterface

interface mmcc_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mag_x;
    logic signed [31:0] mag_y;
    logic signed [15:0] mag_z;
    logic               available;
    logic               calibrating;
    logic               cal_done;

    modport source (
        output valid, mag_x, mag_y, mag_z, available, calibrating, cal_done,
        input  ready
    );
    modport sink (
        input  valid, mag_x, mag_y, mag_z, available, calibrating, cal_done,
        output ready
    );
endinterface

### hw/rtl/mmcc_div.sv
module mmcc_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

### hw/rtl/mmcc_datapath.sv
module mmcc_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [9:0]             cfg_wdata,
    input  logic [1:0]             op,
    input  logic [7:0]             status_one,
    input  logic [7:0]             x_low,
    input  logic [7:0]             x_high,
    input  logic [7:0]             y_low,
    input  logic [7:0]             y_high,
    input  logic [7:0]             z_low,
    input  logic [7:0]             z_high,
    input  logic [7:0]             status_two,
    input  mmcc_pkg::cmd_t         cmd,
    output mmcc_pkg::status_t      status,
    output logic signed [31:0]     mag_x,
    output logic signed [31:0]     mag_y,
    output logic signed [15:0]     mag_z,
    output logic                   available,
    output logic                   calibrating,
    output logic                   cal_done
);

    localparam int RAW_W   = mmcc_pkg::RAW_W;
    localparam int XR_W    = mmcc_pkg::XR_W;
    localparam int HY_W    = mmcc_pkg::HY_W;
    localparam int MAG_W   = mmcc_pkg::MAG_W;
    localparam int CNT_W   = mmcc_pkg::CNT_W;
    localparam int SCALE_W = mmcc_pkg::SCALE_W;
    localparam int OUT_W   = mmcc_pkg::OUT_W;
    localparam int OFF_W   = mmcc_pkg::OFF_W;
    localparam int SUM_W   = mmcc_pkg::SUM_W;
    localparam int PROD_W  = mmcc_pkg::PROD_W;
    localparam int QW      = MAG_W + FRAC_BITS;
    localparam int SQ_W    = (QW + 1 > OUT_W + 1) ? QW + 1 : OUT_W + 1;

    localparam logic signed [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0]   ROUND_ADD = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [SUM_W-1:0]   SAT_HI    = SUM_W'(mmcc_pkg::INT32_MAX);
    localparam logic signed [SUM_W-1:0]   SAT_LO    = SUM_W'(mmcc_pkg::INT32_MIN);
    localparam logic signed [SQ_W-1:0]    SQ_HI     = SQ_W'(mmcc_pkg::INT32_MAX);
    localparam logic signed [SQ_W-1:0]    SQ_LO     = SQ_W'(mmcc_pkg::INT32_MIN);

    // captured request
    logic [1:0]              op_reg;
    logic                    rdy_reg;
    logic                    ovf_reg;
    logic signed [RAW_W-1:0] rx_reg;
    logic signed [RAW_W-1:0] ry_reg;
    logic signed [RAW_W-1:0] rz_reg;

    // calibration state
    logic [CNT_W-1:0]          cal_samples_reg;
    logic signed [RAW_W-1:0]   x_max_reg;
    logic signed [RAW_W-1:0]   x_min_reg;
    logic signed [RAW_W-1:0]   y_max_reg;
    logic signed [RAW_W-1:0]   y_min_reg;
    logic signed [SCALE_W-1:0] y_scale_reg;
    logic signed [OFF_W-1:0]   x_offset_reg;
    logic signed [OFF_W-1:0]   y_offset_reg;
    logic signed [OUT_W-1:0]   held_x_reg;
    logic signed [OUT_W-1:0]   held_y_reg;
    logic signed [RAW_W-1:0]   held_z_reg;
    logic                      cal_active_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      avail_reg;
    logic                      done_reg;

    // arithmetic scratch
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_x_reg;
    logic signed [SUM_W-1:0]  sum_y_reg;
    logic signed [HY_W-1:0]   hy_reg;
    logic                     neg_reg;
    logic                     yr_zero_reg;

    // result register
    logic signed [OUT_W-1:0] out_x_reg;
    logic signed [OUT_W-1:0] out_y_reg;
    logic signed [RAW_W-1:0] out_z_reg;
    logic                    out_avail_reg;
    logic                    out_cal_reg;
    logic                    out_done_reg;

    logic [CNT_W-1:0]          count_inc;
    logic signed [SUM_W-1:0]   rx_ext;
    logic signed [SUM_W-1:0]   sum_x_next;
    logic signed [SCALE_W-1:0] mul_a;
    logic signed [HY_W-1:0]    mul_b;
    logic signed [XR_W-1:0]    xr;
    logic signed [XR_W-1:0]    yr;
    logic [MAG_W-1:0]          xr_mag;
    logic [MAG_W-1:0]          yr_mag;
    logic [QW-1:0]             div_num;
    logic                      div_busy;
    logic [QW-1:0]             div_quo;
    logic signed [HY_W-1:0]    xs_neg;
    logic signed [HY_W-1:0]    ys_neg;
    logic signed [QW:0]        q_sgn;
    logic signed [SQ_W-1:0]    q_ext;
    logic signed [SCALE_W-1:0] scale_sat;
    logic signed [PROD_W-1:0]  p_adj;
    logic signed [PROD_W-1:0]  p_half;

    // divide by 2^FRAC_BITS toward zero, then clamp to int32
    function automatic logic signed [OUT_W-1:0] to_int(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] q;
        logic signed [OUT_W-1:0] r;
        if (s[SUM_W-1])
        begin
            t = s + ROUND_ADD;
        end
        else
        begin
            t = s;
        end
        q = t >>> FRAC_BITS;
        if (q > SAT_HI)
        begin
            r = mmcc_pkg::INT32_MAX;
        end
        else if (q < SAT_LO)
        begin
            r = mmcc_pkg::INT32_MIN;
        end
        else
        begin
            r = q[OUT_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        count_inc  = count_reg + 1'b1;
        rx_ext     = SUM_W'(rx_reg);
        sum_x_next = (rx_ext <<< FRAC_BITS) + SUM_W'(x_offset_reg);
        mul_a      = y_scale_reg;
        mul_b      = cmd.mul_fin ? hy_reg : HY_W'(ry_reg);

        xr     = XR_W'(x_max_reg) - XR_W'(x_min_reg);
        yr     = XR_W'(y_max_reg) - XR_W'(y_min_reg);
        xr_mag = xr[XR_W-1] ? MAG_W'(-xr) : MAG_W'(xr);
        yr_mag = yr[XR_W-1] ? MAG_W'(-yr) : MAG_W'(yr);
        div_num = QW'(xr_mag) << FRAC_BITS;
        xs_neg = -(HY_W'(x_max_reg) + HY_W'(x_min_reg));
        ys_neg = -(HY_W'(y_max_reg) + HY_W'(y_min_reg));

        q_sgn = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        q_ext = SQ_W'(q_sgn);
        if (q_ext > SQ_HI)
        begin
            scale_sat = mmcc_pkg::INT32_MAX;
        end
        else if (q_ext < SQ_LO)
        begin
            scale_sat = mmcc_pkg::INT32_MIN;
        end
        else
        begin
            scale_sat = q_ext[SCALE_W-1:0];
        end

        if (prod_reg[PROD_W-1])
        begin
            p_adj = prod_reg + PROD_W'(1);
        end
        else
        begin
            p_adj = prod_reg;
        end
        p_half = p_adj >>> 1;
    end

    mmcc_div #(
        .NUM_W (QW),
        .DEN_W (MAG_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.fin_start),
        .num   (div_num),
        .den   (yr_mag),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg <= mmcc_pkg::CAL_SAMPLES_RST;
            x_max_reg       <= mmcc_pkg::BOUND_LO;
            x_min_reg       <= mmcc_pkg::BOUND_HI;
            y_max_reg       <= mmcc_pkg::BOUND_LO;
            y_min_reg       <= mmcc_pkg::BOUND_HI;
            y_scale_reg     <= SCALE_ONE;
            x_offset_reg    <= '0;
            y_offset_reg    <= '0;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            held_z_reg      <= '0;
            cal_active_reg  <= 1'b0;
            count_reg       <= '0;
            avail_reg       <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cal_samples_reg <= cfg_wdata;
            end
            if (cmd.capture)
            begin
                avail_reg <= 1'b0;
                done_reg  <= 1'b0;
            end
            if (cmd.clear_held)
            begin
                held_x_reg <= '0;
                held_y_reg <= '0;
                held_z_reg <= '0;
            end
            if (cmd.start_cal)
            begin
                x_max_reg      <= mmcc_pkg::BOUND_LO;
                x_min_reg      <= mmcc_pkg::BOUND_HI;
                y_max_reg      <= mmcc_pkg::BOUND_LO;
                y_min_reg      <= mmcc_pkg::BOUND_HI;
                y_scale_reg    <= SCALE_ONE;
                x_offset_reg   <= '0;
                y_offset_reg   <= '0;
                count_reg      <= '0;
                cal_active_reg <= 1'b1;
            end
            if (cmd.correct)
            begin
                held_x_reg <= to_int(sum_x_reg);
                held_y_reg <= to_int(sum_y_reg);
                held_z_reg <= rz_reg;
                avail_reg  <= 1'b1;
                // coefficients are identity while gathering, so raw equals held
                if (cal_active_reg)
                begin
                    if (rx_reg > x_max_reg)
                    begin
                        x_max_reg <= rx_reg;
                    end
                    if (rx_reg < x_min_reg)
                    begin
                        x_min_reg <= rx_reg;
                    end
                    if (ry_reg > y_max_reg)
                    begin
                        y_max_reg <= ry_reg;
                    end
                    if (ry_reg < y_min_reg)
                    begin
                        y_min_reg <= ry_reg;
                    end
                    count_reg <= count_inc;
                end
            end
            if (cmd.fin_start)
            begin
                x_offset_reg <= OFF_W'(xs_neg) <<< (FRAC_BITS - 1);
            end
            if (cmd.scale_load)
            begin
                y_scale_reg <= yr_zero_reg ? mmcc_pkg::INT32_MAX : scale_sat;
            end
            if (cmd.yoff_load)
            begin
                y_offset_reg   <= p_half[OFF_W-1:0];
                cal_active_reg <= 1'b0;
                done_reg       <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            rdy_reg <= status_one[mmcc_pkg::STATUS1_READY_BIT];
            ovf_reg <= status_two[mmcc_pkg::STATUS2_OVF_BIT];
            rx_reg  <= {x_high, x_low};
            ry_reg  <= {y_high, y_low};
            rz_reg  <= {z_high, z_low};
        end
        if (cmd.mul_sample || cmd.mul_fin)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.mul_sample)
        begin
            sum_x_reg <= sum_x_next;
        end
        if (cmd.add)
        begin
            sum_y_reg <= SUM_W'(prod_reg) + SUM_W'(y_offset_reg);
        end
        if (cmd.fin_start)
        begin
            hy_reg      <= ys_neg;
            neg_reg     <= xr[XR_W-1] ^ yr[XR_W-1];
            yr_zero_reg <= (yr == '0);
        end
        if (cmd.out_load)
        begin
            out_x_reg     <= held_x_reg;
            out_y_reg     <= held_y_reg;
            out_z_reg     <= held_z_reg;
            out_avail_reg <= avail_reg;
            out_cal_reg   <= cal_active_reg;
            out_done_reg  <= done_reg;
        end
    end

    always_comb
    begin
        status.op         = op_reg;
        status.data_ready = rdy_reg;
        status.overflow   = ovf_reg;
        status.cal_active = cal_active_reg;
        status.count_hit  = cal_active_reg && (count_inc >= cal_samples_reg);
        status.div_busy   = div_busy;
    end

    assign mag_x       = out_x_reg;
    assign mag_y       = out_y_reg;
    assign mag_z       = out_z_reg;
    assign available   = out_avail_reg;
    assign calibrating = out_cal_reg;
    assign cal_done    = out_done_reg;

endmodule

### hw/rtl/mmcc_ctrl.sv
module mmcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output mmcc_pkg::cmd_t    cmd,
    input  mmcc_pkg::status_t status
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_CORR   = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_SCALE  = 4'd7;
    localparam logic [3:0] S_YMUL   = 4'd8;
    localparam logic [3:0] S_YOFF   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.op)
                    mmcc_pkg::OP_SAMPLE:
                    begin
                        if (!status.data_ready)
                        begin
                            state_next = S_OUT;
                        end
                        else if (status.overflow)
                        begin
                            cmd.clear_held = 1'b1;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            state_next = S_MUL;
                        end
                    end
                    mmcc_pkg::OP_START:
                    begin
                        cmd.start_cal = 1'b1;
                        state_next    = S_OUT;
                    end
                    mmcc_pkg::OP_STOP:
                    begin
                        state_next = status.cal_active ? S_FIN : S_OUT;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul_sample = 1'b1;
                state_next     = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_CORR;
            end
            S_CORR:
            begin
                cmd.correct = 1'b1;
                state_next  = status.count_hit ? S_FIN : S_OUT;
            end
            S_FIN:
            begin
                cmd.fin_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale_load = 1'b1;
                state_next     = S_YMUL;
            end
            S_YMUL:
            begin
                cmd.mul_fin = 1'b1;
                state_next  = S_YOFF;
            end
            S_YOFF:
            begin
                cmd.yoff_load = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

### hw/rtl/mag_minmax_calibration_correction_core.sv
// Each request is captured in IDLE and decoded. A corrected sample passes MUL, ADD and CORR
// to OUT; a command or a sample that is not ready or overflowed goes straight to OUT; a stop
// that finishes (from DECODE) and the sample that completes the gathering (from CORR) pass
// FIN, DIV, SCALE, YMUL and YOFF. One request in flight: the next is accepted only after OUT
// loads the result. DIV waits on the radix-2 scale divider, one quotient bit per cycle.
// Reset (rst_n low, async): identity, bounds +/-32767, held values zero, cal_samples 500.
module mag_minmax_calibration_correction_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    mmcc_req_if.sink    req,
    mmcc_rsp_if.source  rsp
);

    mmcc_pkg::cmd_t    cmd;
    mmcc_pkg::status_t status;
    logic              req_ready;
    logic              rsp_valid;

    mmcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    mmcc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .op          (req.op),
        .status_one  (req.status_one),
        .x_low       (req.x_low),
        .x_high      (req.x_high),
        .y_low       (req.y_low),
        .y_high      (req.y_high),
        .z_low       (req.z_low),
        .z_high      (req.z_high),
        .status_two  (req.status_two),
        .cmd         (cmd),
        .status      (status),
        .mag_x       (rsp.mag_x),
        .mag_y       (rsp.mag_y),
        .mag_z       (rsp.mag_z),
        .available   (rsp.available),
        .calibrating (rsp.calibrating),
        .cal_done    (rsp.cal_done)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule

### hw/rtl/mmcc_checker.sv
module mmcc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic signed [31:0] mag_x,
    input logic signed [31:0] mag_y,
    input logic               calibrating,
    input logic               cal_done
);

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    a_done_ends_gathering: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && cal_done |-> !calibrating)
        else $error("cal_done reported while still calibrating");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(mag_x) && $stable(mag_y) && $stable(cal_done))
        else $error("result payload changed while stalled");

endmodule

bind mag_minmax_calibration_correction_core mmcc_checker u_mmcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .mag_x       (rsp.mag_x),
    .mag_y       (rsp.mag_y),
    .calibrating (rsp.calibrating),
    .cal_done    (rsp.cal_done)
);

### test/tb_mag_minmax_calibration_correction_core.sv
`timescale 1ns / 100ps

module tb_mag_minmax_calibration_correction_core;

    localparam logic [1:0]         OP_SAMPLE         = mmcc_pkg::OP_SAMPLE;
    localparam logic [1:0]         OP_START          = mmcc_pkg::OP_START;
    localparam logic [1:0]         OP_STOP           = mmcc_pkg::OP_STOP;
    localparam int                 STATUS1_READY_BIT = mmcc_pkg::STATUS1_READY_BIT;
    localparam int                 STATUS2_OVF_BIT   = mmcc_pkg::STATUS2_OVF_BIT;
    localparam logic signed [31:0] INT32_MAX         = mmcc_pkg::INT32_MAX;
    localparam logic signed [31:0] INT32_MIN         = mmcc_pkg::INT32_MIN;
    localparam logic signed [15:0] BOUND_HI          = mmcc_pkg::BOUND_HI;
    localparam logic signed [15:0] BOUND_LO          = mmcc_pkg::BOUND_LO;
    localparam logic [9:0]         CAL_SAMPLES_RST   = mmcc_pkg::CAL_SAMPLES_RST;

    localparam int         FRAC_BITS    = 16;
    localparam longint     Q_ONE        = longint'(1) << FRAC_BITS;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = FRAC_BITS + 30;
    localparam int         RANDOM_ITEMS = 1500;
    localparam int         CALM_ITEMS   = 150;
    localparam int         PRESSURE_AT  = 400;
    localparam int         MAX_REPORTS  = 10;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  status_one;
        logic [15:0] x_word;
        logic [15:0] y_word;
        logic [15:0] z_word;
        logic [7:0]  status_two;
    } mag_read_t;

    typedef struct {
        logic signed [31:0] mag_x;
        logic signed [31:0] mag_y;
        logic signed [15:0] mag_z;
        logic               available;
        logic               calibrating;
        logic               cal_done;
    } mag_out_t;

    typedef struct {
        bit         is_cfg;
        logic [9:0] cfg_value;
        mag_read_t  rd;
        bit         typed;
        mag_out_t   want;
    } step_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [9:0] cfg_wdata = '0;

    mmcc_req_if req_bus ();
    mmcc_rsp_if rsp_bus ();

    mag_minmax_calibration_correction_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(req_bus),
        .rsp(rsp_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // calibration model state
    logic [9:0]         cal_target;
    int                 x_top, x_bot, y_top, y_bot;
    int                 y_gain;
    longint             x_bias, y_bias;
    int                 hold_x, hold_y;
    logic signed [15:0] hold_z;
    bit                 gathering;
    logic [9:0]         gathered;

    mag_out_t  corrected_q[$];
    mag_out_t  no_want;
    step_row_t steps[$];

    int reads_sent     = 0;
    int calm_from      = 32'h7FFF_FFFF;
    int fault_count    = 0;
    int quiet_cycles   = 0;
    bit calm           = 1'b0;
    bit gaps_on        = 1'b1;
    bit hold_rsp       = 1'b0;
    bit pressure_given = 1'b0;

    function automatic bit coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int clamp_int32(longint v);
        if (v > longint'(INT32_MAX))
            return INT32_MAX;
        if (v < longint'(INT32_MIN))
            return INT32_MIN;
        return int'(v);
    endfunction

    function automatic void reset_bounds();
        x_top  = BOUND_LO;
        x_bot  = BOUND_HI;
        y_top  = BOUND_LO;
        y_bot  = BOUND_HI;
        y_gain = int'(Q_ONE);
        x_bias = 0;
        y_bias = 0;
    endfunction

    function automatic void fit_coefficients();
        longint xr, yr, hy;
        xr = longint'(x_top) - longint'(x_bot);
        yr = longint'(y_top) - longint'(y_bot);
        if (yr == 0)
            y_gain = INT32_MAX;
        else
            y_gain = clamp_int32((xr * Q_ONE) / yr);
        x_bias = xr * (Q_ONE / 2) - longint'(x_top) * Q_ONE;
        hy = yr - 2 * longint'(y_top);
        y_bias = (longint'(y_gain) * hy) / 2;
        gathering = 1'b0;
    endfunction

    function automatic mag_out_t correct_read(mag_read_t rd);
        mag_out_t o;
        bit       fresh;
        bit       done;
        longint   rx, ry;
        fresh = 1'b0;
        done  = 1'b0;
        if (rd.op == OP_SAMPLE)
        begin
            if (rd.status_one[STATUS1_READY_BIT])
            begin
                rx = longint'($signed(rd.x_word));
                ry = longint'($signed(rd.y_word));
                if (rd.status_two[STATUS2_OVF_BIT])
                begin
                    hold_x = 0;
                    hold_y = 0;
                    hold_z = '0;
                end
                else
                begin
                    hold_x = clamp_int32((rx * Q_ONE + x_bias) / Q_ONE);
                    hold_y = clamp_int32((longint'(y_gain) * ry + y_bias) / Q_ONE);
                    hold_z = $signed(rd.z_word);
                    fresh  = 1'b1;
                end
            end
            if (fresh && gathering)
            begin
                if (hold_x > x_top) x_top = hold_x;
                if (hold_x < x_bot) x_bot = hold_x;
                if (hold_y > y_top) y_top = hold_y;
                if (hold_y < y_bot) y_bot = hold_y;
                gathered = gathered + 10'd1;
                if (gathered >= cal_target)
                begin
                    fit_coefficients();
                    done = 1'b1;
                end
            end
        end
        else if (rd.op == OP_START)
        begin
            reset_bounds();
            gathered  = '0;
            gathering = 1'b1;
        end
        else if (rd.op == OP_STOP && gathering)
        begin
            fit_coefficients();
            done = 1'b1;
        end
        o.mag_x       = hold_x;
        o.mag_y       = hold_y;
        o.mag_z       = hold_z;
        o.available   = fresh;
        o.calibrating = gathering;
        o.cal_done    = done;
        return o;
    endfunction

    function automatic step_row_t read_row(logic [1:0] op, logic [7:0] s1, logic [15:0] xw,
                                           logic [15:0] yw, logic [15:0] zw, logic [7:0] s2);
        step_row_t r;
        r.is_cfg        = 1'b0;
        r.cfg_value     = '0;
        r.typed         = 1'b0;
        r.rd.op         = op;
        r.rd.status_one = s1;
        r.rd.x_word     = xw;
        r.rd.y_word     = yw;
        r.rd.z_word     = zw;
        r.rd.status_two = s2;
        return r;
    endfunction

    function automatic step_row_t known(step_row_t r, int mx, int my, int mz,
                                        bit av, bit ca, bit dn);
        r.typed            = 1'b1;
        r.want.mag_x       = mx;
        r.want.mag_y       = my;
        r.want.mag_z       = mz[15:0];
        r.want.available   = av;
        r.want.calibrating = ca;
        r.want.cal_done    = dn;
        return r;
    endfunction

    function automatic step_row_t cfg_row(logic [9:0] v);
        step_row_t r;
        r = read_row(OP_SAMPLE, '0, '0, '0, '0, '0);
        r.is_cfg    = 1'b1;
        r.cfg_value = v;
        return r;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic mag_read_t noise_read();
        mag_read_t rd;
        rd.op         = 2'($urandom);
        rd.status_one = 8'($urandom);
        rd.x_word     = rand_word();
        rd.y_word     = rand_word();
        rd.z_word     = rand_word();
        rd.status_two = 8'($urandom);
        return rd;
    endfunction

    function automatic mag_read_t cmd_read(logic [1:0] op);
        mag_read_t rd;
        rd    = noise_read();
        rd.op = op;
        return rd;
    endfunction

    function automatic mag_read_t good_read();
        mag_read_t rd;
        rd = cmd_read(OP_SAMPLE);
        rd.status_one[STATUS1_READY_BIT] = 1'b1;
        rd.status_two[STATUS2_OVF_BIT]   = 1'b0;
        return rd;
    endfunction

    function automatic mag_read_t bad_read();
        mag_read_t rd;
        rd = good_read();
        if (coin(50))
            rd.status_one[STATUS1_READY_BIT] = 1'b0;
        else
            rd.status_two[STATUS2_OVF_BIT] = 1'b1;
        return rd;
    endfunction

    task automatic send_read(mag_read_t rd, bit typed, mag_out_t want);
        mag_out_t predicted;
        if (!pressure_given && reads_sent >= PRESSURE_AT)
        begin
            pressure_given = 1'b1;
            hold_rsp       = 1'b1;
        end
        calm = reads_sent >= calm_from;
        @(negedge clk);
        if (gaps_on && !calm && coin(25))
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        req_bus.op         <= rd.op;
        req_bus.status_one <= rd.status_one;
        req_bus.x_low      <= rd.x_word[7:0];
        req_bus.x_high     <= rd.x_word[15:8];
        req_bus.y_low      <= rd.y_word[7:0];
        req_bus.y_high     <= rd.y_word[15:8];
        req_bus.z_low      <= rd.z_word[7:0];
        req_bus.z_high     <= rd.z_word[15:8];
        req_bus.status_two <= rd.status_two;
        req_bus.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!req_bus.ready);
        predicted = correct_read(rd);
        if (typed)
            corrected_q.push_back(want);
        else
            corrected_q.push_back(predicted);
        reads_sent++;
    endtask

    task automatic send_plain(mag_read_t rd);
        send_read(rd, 1'b0, no_want);
    endtask

    task automatic write_cal_samples(logic [9:0] value);
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (corrected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we     <= 1'b0;
        cal_target  = value;
    endtask

    task automatic run_phase(logic [9:0] target, bit full_gather);
        int pick;
        write_cal_samples(target);
        gaps_on = coin(75);
        repeat ($urandom_range(0, 4)) send_plain(noise_read());
        send_plain(cmd_read(OP_START));
        while (gathering)
        begin
            pick = $urandom_range(0, 99);
            if (!full_gather && pick < 2)
                send_plain(cmd_read(OP_STOP));
            else if (!full_gather && pick < 3)
                send_plain(cmd_read(OP_START));
            else if (pick < 12)
                send_plain(bad_read());
            else
                send_plain(good_read());
        end
        repeat ($urandom_range(2, 12))
        begin
            if (coin(85))
                send_plain(good_read());
            else
                send_plain(noise_read());
        end
    endtask

    // response side: random back-pressure plus one long hold-off
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_bus.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_rsp       = 1'b0;
                rsp_bus.ready <= 1'b1;
            end
            else if (gaps_on && !calm && coin(25))
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                rsp_bus.ready <= 1'b1;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        mag_out_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (corrected_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result: x=%0d y=%0d z=%0d", rsp_bus.mag_x,
                             rsp_bus.mag_y, rsp_bus.mag_z);
            end
            else
            begin
                want = corrected_q.pop_front();
                if (want.mag_x !== rsp_bus.mag_x || want.mag_y !== rsp_bus.mag_y ||
                    want.mag_z !== rsp_bus.mag_z || want.available !== rsp_bus.available ||
                    want.calibrating !== rsp_bus.calibrating ||
                    want.cal_done !== rsp_bus.cal_done)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("mismatch: want x=%0d y=%0d z=%0d av=%0b cal=%0b done=%0b",
                                 want.mag_x, want.mag_y, want.mag_z, want.available,
                                 want.calibrating, want.cal_done, "\n          got  ",
                                 "x=%0d y=%0d z=%0d av=%0b cal=%0b done=%0b",
                                 rsp_bus.mag_x, rsp_bus.mag_y, rsp_bus.mag_z,
                                 rsp_bus.available, rsp_bus.calibrating, rsp_bus.cal_done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [9:0] target;

        req_bus.valid      = 1'b0;
        req_bus.op         = OP_SAMPLE;
        req_bus.status_one = '0;
        req_bus.x_low      = '0;
        req_bus.x_high     = '0;
        req_bus.y_low      = '0;
        req_bus.y_high     = '0;
        req_bus.z_low      = '0;
        req_bus.z_high     = '0;
        req_bus.status_two = '0;

        cal_target = CAL_SAMPLES_RST;
        reset_bounds();
        hold_x    = 0;
        hold_y    = 0;
        hold_z    = '0;
        gathering = 1'b0;
        gathered  = '0;

        // identity, not ready, overflow, idle commands
        steps.push_back(known(read_row(OP_SAMPLE, 8'h01, 16'h7FFF, 16'h8000, 16'h8000, 8'h00),
                              32767, -32768, -32768, 1, 0, 0));
        steps.push_back(known(read_row(OP_SAMPLE, 8'hFE, 16'h1234, 16'h5678, 16'h9ABC, 8'h00),
                              32767, -32768, -32768, 0, 0, 0));
        steps.push_back(known(read_row(OP_SAMPLE, 8'h01, 16'h1111, 16'h2222, 16'h3333, 8'h08),
                              0, 0, 0, 0, 0, 0));
        steps.push_back(known(read_row(OP_STOP, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00),
                              0, 0, 0, 0, 0, 0));
        steps.push_back(known(read_row(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF),
                              0, 0, 0, 0, 0, 0));
        steps.push_back(known(read_row(OP_SAMPLE, 8'hFF, 16'h8000, 16'h7FFF, 16'h7FFF, 8'hF7),
                              -32768, 32767, 32767, 1, 0, 0));
        // stop with nothing gathered keeps identity
        steps.push_back(known(read_row(OP_START, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00),
                              -32768, 32767, 32767, 0, 1, 0));
        steps.push_back(known(read_row(OP_STOP, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00),
                              -32768, 32767, 32767, 0, 0, 1));
        steps.push_back(known(read_row(OP_SAMPLE, 8'h01, 16'h0100, 16'h0200, 16'h0003, 8'h00),
                              256, 512, 3, 1, 0, 0));
        // restart while gathering, full range, early stop
        steps.push_back(read_row(OP_START, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
        steps.push_back(read_row(OP_SAMPLE, 8'h01, 16'h0064, 16'h0005, 16'h0000, 8'h00));
        steps.push_back(read_row(OP_START, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
        steps.push_back(known(read_row(OP_SAMPLE, 8'h01, 16'h8000, 16'h7FFF, 16'h0001, 8'h00),
                              -32768, 32767, 1, 1, 1, 0));
        steps.push_back(known(read_row(OP_SAMPLE, 8'h01, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h00),
                              32767, -32768, -1, 1, 1, 0));
        steps.push_back(read_row(OP_SAMPLE, 8'h00, 16'h4444, 16'h5555, 16'h6666, 8'h00));
        steps.push_back(known(read_row(OP_SAMPLE, 8'hFF, 16'h4444, 16'h5555, 16'h6666, 8'hFF),
                              0, 0, 0, 0, 1, 0));
        steps.push_back(read_row(OP_STOP, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
        steps.push_back(read_row(OP_SAMPLE, 8'h01, 16'h1234, 16'hF00D, 16'h4567, 8'h00));
        // single-sample gather: zero y range saturates the scale
        steps.push_back(cfg_row(10'd1));
        steps.push_back(read_row(OP_START, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
        steps.push_back(known(read_row(OP_SAMPLE, 8'h01, 16'h0010, 16'h0020, 16'h0030, 8'h00),
                              16, 32, 48, 1, 0, 1));
        steps.push_back(read_row(OP_SAMPLE, 8'h01, 16'h0010, 16'h7FFF, 16'h0000, 8'h00));
        steps.push_back(read_row(OP_SAMPLE, 8'h01, 16'h0010, 16'h8000, 16'h0000, 8'h00));
        steps.push_back(cfg_row(10'd0));
        steps.push_back(read_row(OP_START, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
        steps.push_back(known(read_row(OP_SAMPLE, 8'h01, 16'hFFFF, 16'h0001, 16'h0002, 8'h00),
                              -1, 1, 2, 1, 0, 1));
        steps.push_back(cfg_row(10'd1023));
        steps.push_back(read_row(OP_START, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
        steps.push_back(read_row(OP_STOP, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
                write_cal_samples(steps[i].cfg_value);
            else
                send_read(steps[i].rd, steps[i].typed, steps[i].want);
        end

        calm_from = reads_sent + RANDOM_ITEMS - CALM_ITEMS;
        run_phase(10'd1023, 1'b1);
        while (reads_sent < calm_from + CALM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: target = 10'd0;
                1: target = 10'd1;
                2: target = 10'd1023;
                default: target = 10'($urandom_range(2, 40));
            endcase
            run_phase(target, 1'b0);
        end

        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (corrected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && corrected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
